// ----- design/lkvc_pkg.sv -----
package lkvc_pkg;

	// Field widths of one word on each channel
	localparam int KEY_W  = 32;
	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;

	// Capacity after reset, and the value returned by a get that misses
	localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
	localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

	// Request class, decided in the front end
	typedef enum logic [0:0] {
		OP_GET = 1'b0,
		OP_SET = 1'b1
	} op_t;

	// One queued request word
	typedef struct packed {
		op_t               op;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] value;
	} item_t;

endpackage

// ----- design/lkvc_ram.sv -----
module lkvc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/lkvc_front.sv -----
module lkvc_front
	import lkvc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              cmd,
	input  logic [KEY_W-1:0]  lookup_key,
	input  logic [DATA_W-1:0] store_value,
	output logic              q_valid,
	output item_t             q_item,
	input  logic              q_pop
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            buf_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	item_t            item_in;

	// Classify the incoming word
	always_comb begin
		item_in.op    = cmd ? OP_SET : OP_GET;
		item_in.key   = lookup_key;
		item_in.value = store_value;
	end

	assign in_stall = (cnt_q == CNT_W'(DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != '0);
	assign q_item   = buf_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= item_in;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- design/lkvc_back.sv -----
module lkvc_back
	import lkvc_pkg::*;
#(
	parameter int MAX_ENTRIES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CAP_W-1:0]  capacity,
	input  logic              q_valid,
	input  item_t             q_item,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              hit,
	output logic [DATA_W-1:0] read_value
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	// Tag cells: valid, key and recency rank per entry (0 = most recent)
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [KEY_W-1:0]       key_q  [MAX_ENTRIES];
	logic [IDX_W-1:0]       rank_q [MAX_ENTRIES];
	logic [CNT_W-1:0]       count_q;

	logic [MAX_ENTRIES-1:0] match;
	logic [MAX_ENTRIES-1:0] free_oh;
	logic [MAX_ENTRIES-1:0] oldest_oh;
	logic                   any_hit;
	logic                   has_free;
	logic [IDX_W-1:0]       hit_idx;
	logic [IDX_W-1:0]       hit_rank;
	logic [IDX_W-1:0]       free_idx;
	logic [IDX_W-1:0]       old_idx;
	logic [IDX_W-1:0]       slot_idx;
	logic [IDX_W-1:0]       oldest_rank;
	logic [CMP_W-1:0]       cap_ext;
	logic [CMP_W-1:0]       cap_eff;
	logic                   full;

	logic                   issue;
	logic                   do_set;
	logic                   do_get;

	logic                   valid_s2;
	logic                   hit_s2;
	logic                   s2_adv;
	logic [DATA_W-1:0]      rdata;

	logic                   out_valid_q;
	logic                   hit_q;
	logic [DATA_W-1:0]      read_value_q;

	// Parallel key compare, free slot and oldest entry search
	always_comb begin
		oldest_rank = IDX_W'(count_q - CNT_W'(1));
		free_oh     = ~valid_q & (valid_q + MAX_ENTRIES'(1));
		has_free    = ~&valid_q;
		hit_idx     = '0;
		hit_rank    = '0;
		free_idx    = '0;
		old_idx     = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			match[i]     = valid_q[i] && (key_q[i] == q_item.key);
			oldest_oh[i] = valid_q[i] && (rank_q[i] == oldest_rank);
			if (match[i]) begin
				hit_idx  = hit_idx | IDX_W'(i);
				hit_rank = hit_rank | rank_q[i];
			end
			if (free_oh[i]) begin
				free_idx = free_idx | IDX_W'(i);
			end
			if (oldest_oh[i]) begin
				old_idx = old_idx | IDX_W'(i);
			end
		end
		any_hit = |match;
	end

	// Clamp capacity to 1..MAX_ENTRIES and pick the target slot of a set
	always_comb begin
		cap_ext = CMP_W'(capacity);
		if (cap_ext == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
			cap_eff = CMP_W'(MAX_ENTRIES);
		end else begin
			cap_eff = cap_ext;
		end
		full = (CMP_W'(count_q) >= cap_eff) || !has_free;
		if (any_hit) begin
			slot_idx = hit_idx;
		end else if (full) begin
			slot_idx = old_idx;
		end else begin
			slot_idx = free_idx;
		end
	end

	// Issue: sets always go, gets only when the read stage is empty or can move on
	assign s2_adv = valid_s2 && (!out_valid_q || !out_stall);
	assign issue  = q_valid && ((q_item.op == OP_SET) || !valid_s2 || s2_adv);
	assign do_set = issue && (q_item.op == OP_SET);
	assign do_get = issue && (q_item.op == OP_GET);
	assign q_pop  = issue;

	// Valid bits, ranks and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (do_set) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (IDX_W'(i) == slot_idx) begin
					valid_q[i] <= 1'b1;
					rank_q[i]  <= '0;
				end else if (valid_q[i] && (!any_hit || (rank_q[i] < hit_rank))) begin
					rank_q[i] <= rank_q[i] + 1'b1;
				end
			end
			if (!any_hit && !full) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Keys are written only when a new entry is placed
	always_ff @(posedge clk) begin
		if (do_set && !any_hit) begin
			key_q[slot_idx] <= q_item.key;
		end
	end

	// Value store
	lkvc_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_ENTRIES)
	) u_data (
		.clk   (clk),
		.we    (do_set),
		.waddr (slot_idx),
		.wdata (q_item.value),
		.re    (do_get),
		.raddr (hit_idx),
		.rdata (rdata)
	);

	// Read stage and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_get) begin
				valid_s2 <= 1'b1;
			end else if (s2_adv) begin
				valid_s2 <= 1'b0;
			end
			if (s2_adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_get) begin
			hit_s2 <= any_hit;
		end
		if (s2_adv) begin
			hit_q        <= hit_s2;
			read_value_q <= hit_s2 ? rdata : MISS_VALUE;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = read_value_q;

endmodule

// ----- design/lru_key_value_cache_unit.sv -----
// Fully associative key-value cache with least recently used replacement.
// Input channel (in_valid / in_stall): one request word per acceptance;
//   cmd 0 is a get of lookup_key, cmd 1 a set of lookup_key to store_value.
// Output channel (out_valid / out_stall): one word (hit, read_value) per get,
//   nothing for a set; a miss returns hit 0 and read_value -1.
// Config channel (cfg_valid / cfg_ready): writes the capacity register;
//   cfg_ready is always high, write only while no request is in flight.
// Throughput: one request per clock while out_stall stays low, set by the parallel key
//   compare and rank update over all entries in the back end.
// A get is compared and its data read as it leaves the queue, then passes
//   the read stage register and the output register before out_valid; it also
//   waits while earlier words wait in the queue.
// A two-word queue sits between the front end and the back end; when
//   out_stall holds, gets back up into the queue and in_stall rises once it
//   is full. Sets keep draining until a get reaches the head of the queue.
// Reset empties the cache and the queue, clears the output and sets the
//   capacity to 16; no clearing pass is needed.
module lru_key_value_cache_unit
	import lkvc_pkg::*;
#(
	parameter int MAX_ENTRIES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              cmd,
	input  logic [KEY_W-1:0]  lookup_key,
	input  logic [DATA_W-1:0] store_value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              hit,
	output logic [DATA_W-1:0] read_value,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CAP_W-1:0]  cfg_data
);

	logic [CAP_W-1:0] capacity_q;
	logic             q_valid;
	item_t            q_item;
	logic             q_pop;

	// Capacity register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	lkvc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.lookup_key  (lookup_key),
		.store_value (store_value),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop)
	);

	lkvc_back #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.capacity   (capacity_q),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit),
		.read_value (read_value)
	);

endmodule

// ----- design/lkvc_checker.sv -----
module lkvc_checker
	import lkvc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic              hit,
	input logic [DATA_W-1:0] read_value
);

	// A stalled result word stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	// A stalled result word keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(hit) && $stable(read_value))
		else $error("result payload changed while stalled");

	// A miss always reports minus one
	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> read_value == MISS_VALUE)
		else $error("miss with a value other than minus one");

	// The queue only fills up right after taking a word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall))
		else $error("input stall raised without an accepted word");

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (.*);

// ----- tb/lru_key_value_cache_unit_tb.sv -----
`timescale 1ns / 100ps

module lru_key_value_cache_unit_tb;
	import lkvc_pkg::*;

	localparam int LRU_DEPTH      = 16;
	// cycles with no word in flight before the capacity may change (pipe plus queue)
	localparam int SETTLE_CYCLES  = 12;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 200;
	localparam int TAIL_ITEMS     = 180;

	typedef enum logic [1:0] {
		ACT_REQ,
		ACT_CFG,
		ACT_DRAIN
	} action_e;

	typedef struct {
		action_e           act;
		op_t               op;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] value;
		logic [CAP_W-1:0]  cap;
		int                gap;
		bit                calm;
	} stim_t;

	typedef struct packed {
		logic              hit;
		logic [DATA_W-1:0] value;
	} lookup_t;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic              cmd         = 1'b0;
	logic [KEY_W-1:0]  lookup_key  = '0;
	logic [DATA_W-1:0] store_value = '0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic              hit;
	logic [DATA_W-1:0] read_value;
	logic              cfg_valid   = 1'b0;
	logic              cfg_ready;
	logic [CAP_W-1:0]  cfg_data    = '0;
	logic              tail_phase  = 1'b0;

	// Shadow copy of the cache contents and the capacity register
	logic              shadow_valid [LRU_DEPTH];
	logic [KEY_W-1:0]  shadow_key   [LRU_DEPTH];
	logic [DATA_W-1:0] shadow_data  [LRU_DEPTH];
	int                shadow_age   [LRU_DEPTH];
	logic [CAP_W-1:0]  shadow_cap;

	stim_t   stim_q[$];
	lookup_t lookup_results_q[$];

	int err_cnt     = 0;
	int gets_sent   = 0;
	int sets_sent   = 0;
	int hits_seen   = 0;
	int misses_seen = 0;
	int cfg_writes  = 0;
	int drains_done = 0;
	int idle_cycles = 0;

	lru_key_value_cache_unit #(
		.MAX_ENTRIES(LRU_DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.lookup_key (lookup_key),
		.store_value(store_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit),
		.read_value (read_value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic note_error(input string msg);
		if (err_cnt < 10)
			$display("ERROR @%0t: %s", $realtime, msg);
		err_cnt++;
	endtask

	// Apply one accepted request word to the shadow cache; a get queues its answer
	task automatic lru_apply(input op_t op, input logic [KEY_W-1:0] k,
			input logic [DATA_W-1:0] v);
		int      i;
		int      slot;
		int      free_slot;
		int      oldest;
		int      count;
		int      limit;
		int      eff_cap;
		lookup_t res;
		slot      = -1;
		free_slot = -1;
		oldest    = -1;
		count     = 0;
		for (i = 0; i < LRU_DEPTH; i++)
			if (slot < 0 && shadow_valid[i] && shadow_key[i] == k)
				slot = i;
		if (op == OP_GET) begin
			res.hit   = (slot >= 0);
			res.value = (slot >= 0) ? shadow_data[slot] : MISS_VALUE;
			lookup_results_q.push_back(res);
		end else if (slot >= 0) begin
			// update in place, entry moves to the front
			limit = shadow_age[slot];
			for (i = 0; i < LRU_DEPTH; i++)
				if (shadow_valid[i] && shadow_age[i] < limit)
					shadow_age[i]++;
			shadow_data[slot] = v;
			shadow_age[slot]  = 0;
		end else begin
			// new key: free slot while below capacity, else evict the oldest
			eff_cap = shadow_cap;
			if (eff_cap < 1)
				eff_cap = 1;
			if (eff_cap > LRU_DEPTH)
				eff_cap = LRU_DEPTH;
			for (i = 0; i < LRU_DEPTH; i++) begin
				if (shadow_valid[i]) begin
					count++;
					if (oldest < 0 || shadow_age[i] > shadow_age[oldest])
						oldest = i;
				end else if (free_slot < 0) begin
					free_slot = i;
				end
			end
			if (count >= eff_cap || free_slot < 0) begin
				shadow_valid[oldest] = 1'b0;
				slot = oldest;
			end else begin
				slot = free_slot;
			end
			for (i = 0; i < LRU_DEPTH; i++)
				if (shadow_valid[i])
					shadow_age[i]++;
			shadow_valid[slot] = 1'b1;
			shadow_key[slot]   = k;
			shadow_data[slot]  = v;
			shadow_age[slot]   = 0;
		end
	endtask

	task automatic add_req(input op_t op, input logic [KEY_W-1:0] k,
			input logic [DATA_W-1:0] v, input int gap, input bit calm);
		stim_t s;
		s.act   = ACT_REQ;
		s.op    = op;
		s.key   = k;
		s.value = v;
		s.cap   = '0;
		s.gap   = gap;
		s.calm  = calm;
		stim_q.push_back(s);
	endtask

	task automatic add_ctrl(input action_e act, input logic [CAP_W-1:0] cap);
		stim_t s;
		s.act   = act;
		s.op    = OP_GET;
		s.key   = '0;
		s.value = '0;
		s.cap   = cap;
		s.gap   = 0;
		s.calm  = 1'b0;
		stim_q.push_back(s);
	endtask

	// One phase of random traffic over a key pool a little larger than the capacity
	task automatic add_random_phase(input logic [CAP_W-1:0] cap, input int n,
			input bit calm, input bit with_drain);
		logic [KEY_W-1:0] pool[$];
		logic [KEY_W-1:0] k;
		int               pool_n;
		int               eff_cap;
		int               gap_pct;
		int               gap;
		int               i;
		eff_cap = (cap < 1) ? 1 : ((cap > LRU_DEPTH) ? LRU_DEPTH : cap);
		pool_n  = eff_cap + $urandom_range(1, 8);
		gap_pct = 0;
		for (i = 0; i < pool_n; i++) begin
			case ($urandom_range(0, 9))
				0:       pool.push_back(32'h8000_0000);
				1:       pool.push_back(32'h7FFF_FFFF);
				2:       pool.push_back(32'hFFFF_FFFF);
				3:       pool.push_back(32'h0000_0000);
				default: pool.push_back($urandom);
			endcase
		end
		for (i = 0; i < n; i++) begin
			// idle density changes in stretches, some with no gaps at all
			if (i % 40 == 0) begin
				case ($urandom_range(0, 2))
					0:       gap_pct = 0;
					1:       gap_pct = 6;
					default: gap_pct = 25;
				endcase
			end
			gap = (!calm && $urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 14) : 0;
			if ($urandom_range(0, 99) < 85)
				k = pool[$urandom_range(0, pool_n - 1)];
			else
				k = $urandom;
			add_req($urandom_range(0, 1) ? OP_SET : OP_GET, k, $urandom, gap, calm);
			if (with_drain && i == n / 2)
				add_ctrl(ACT_DRAIN, '0);
		end
	endtask

	// Request driver
	always @(posedge clk) begin : drive_blk
		logic next_in_valid;
		logic next_cfg_valid;
		stim_t s;
		int gap_left;
		int settle_cnt;
		if (!arst_n) begin
			gap_left   = 0;
			settle_cnt = 0;
		end else begin
			next_in_valid  = in_valid;
			next_cfg_valid = cfg_valid;
			if (in_valid && !in_stall) begin
				lru_apply(op_t'(cmd), lookup_key, store_value);
				if (cmd == OP_GET)
					gets_sent++;
				else
					sets_sent++;
				next_in_valid = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				shadow_cap = cfg_data;
				cfg_writes++;
				next_cfg_valid = 1'b0;
			end
			// block counts as idle once nothing is owed and no word is offered
			if (in_valid || cfg_valid || lookup_results_q.size() != 0)
				settle_cnt = 0;
			else if (settle_cnt < SETTLE_CYCLES)
				settle_cnt++;
			if (!next_in_valid && !next_cfg_valid && stim_q.size() != 0) begin
				if (stim_q[0].gap > 0) begin
					gap_left        = stim_q[0].gap;
					stim_q[0].gap   = 0;
				end
				if (gap_left > 0) begin
					gap_left--;
				end else begin
					s = stim_q[0];
					case (s.act)
						ACT_REQ: begin
							next_in_valid = 1'b1;
							cmd         <= s.op;
							lookup_key  <= s.key;
							store_value <= s.value;
							tail_phase  <= s.calm;
							void'(stim_q.pop_front());
						end
						ACT_CFG: begin
							if (settle_cnt >= SETTLE_CYCLES) begin
								next_cfg_valid = 1'b1;
								cfg_data <= s.cap;
								void'(stim_q.pop_front());
							end
						end
						default: begin
							if (settle_cnt >= SETTLE_CYCLES) begin
								drains_done++;
								void'(stim_q.pop_front());
							end
						end
					endcase
				end
			end
			in_valid  <= next_in_valid;
			cfg_valid <= next_cfg_valid;
		end
	end

	// Result monitor and back-pressure
	always @(posedge clk) begin : mon_blk
		logic next_stall;
		lookup_t want;
		int stall_left;
		int quiet_left;
		if (!arst_n) begin
			stall_left = 0;
			quiet_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (lookup_results_q.size() == 0) begin
					note_error($sformatf("result with none owed: hit %0b value %08h",
						hit, read_value));
				end else begin
					want = lookup_results_q.pop_front();
					if (hit !== want.hit)
						note_error($sformatf("hit: expected %0b, got %0b", want.hit, hit));
					if (read_value !== want.value)
						note_error($sformatf("read_value: expected %08h, got %08h",
							want.value, read_value));
					if (want.hit)
						hits_seen++;
					else
						misses_seen++;
				end
			end
			next_stall = 1'b0;
			if (stall_left > 0) begin
				stall_left--;
				next_stall = 1'b1;
			end else if (quiet_left > 0) begin
				quiet_left--;
			end else if (!tail_phase) begin
				case ($urandom_range(0, 99))
					0, 1:          quiet_left = $urandom_range(20, 80);
					2, 3, 4, 5, 6: begin
						stall_left = $urandom_range(1, 14) - 1;
						next_stall = 1'b1;
					end
					default: ;
				endcase
			end
			out_stall <= next_stall;
		end
	end

	// Watchdog on cycles with no accepted word on any channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin : main_blk
		int i;
		shadow_cap = CAP_RESET;
		for (i = 0; i < LRU_DEPTH; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_key[i]   = '0;
			shadow_data[i]  = '0;
			shadow_age[i]   = 0;
		end

		// Directed: empty miss, extreme keys and values, update, key -1 holding -1
		add_req(OP_GET, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);
		add_req(OP_SET, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1'b0);
		add_req(OP_SET, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1'b0);
		add_req(OP_SET, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);
		add_req(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0);
		add_req(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 0, 1'b0);
		add_req(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF, 0, 1'b0);
		add_req(OP_GET, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);
		add_req(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, 0, 1'b0);
		add_req(OP_GET, 32'h0000_0001, 32'h0000_0000, 0, 1'b0);
		add_req(OP_SET, 32'h0000_0000, 32'h1234_5678, 0, 1'b0);
		add_req(OP_GET, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);
		// Capacity dropped below the fill level: one eviction per new key
		add_ctrl(ACT_CFG, 5'd1);
		add_req(OP_SET, 32'h0000_0005, 32'h0000_0005, 0, 1'b0);
		add_req(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 0, 1'b0);
		add_req(OP_GET, 32'h8000_0000, 32'h0000_0000, 0, 1'b0);
		add_req(OP_SET, 32'h0000_0006, 32'h0000_0006, 0, 1'b0);
		add_req(OP_GET, 32'h8000_0000, 32'h0000_0000, 0, 1'b0);
		add_req(OP_GET, 32'h0000_0006, 32'h0000_0000, 0, 1'b0);
		// Zero capacity acts as one
		add_ctrl(ACT_CFG, 5'd0);
		add_req(OP_SET, 32'h0000_0007, 32'hA5A5_A5A5, 0, 1'b0);
		add_req(OP_SET, 32'h0000_0008, 32'h5A5A_5A5A, 0, 1'b0);
		add_req(OP_GET, 32'h0000_0007, 32'h0000_0000, 0, 1'b0);
		add_req(OP_GET, 32'h0000_0008, 32'h0000_0000, 0, 1'b0);

		// Random phases across the capacity range, above the top included
		add_ctrl(ACT_CFG, 5'd31);
		add_random_phase(5'd31, PHASE_ITEMS, 1'b0, 1'b1);
		add_ctrl(ACT_CFG, 5'd2);
		add_random_phase(5'd2, PHASE_ITEMS, 1'b0, 1'b0);
		add_ctrl(ACT_CFG, 5'd16);
		add_random_phase(5'd16, PHASE_ITEMS, 1'b0, 1'b1);
		add_ctrl(ACT_CFG, 5'd5);
		add_random_phase(5'd5, PHASE_ITEMS, 1'b0, 1'b0);
		add_ctrl(ACT_CFG, 5'd0);
		add_random_phase(5'd0, PHASE_ITEMS, 1'b0, 1'b0);
		i = $urandom_range(1, 15);
		add_ctrl(ACT_CFG, i[CAP_W-1:0]);
		add_random_phase(i[CAP_W-1:0], PHASE_ITEMS, 1'b0, 1'b1);
		// Tail without idling on either side
		add_ctrl(ACT_CFG, 5'd16);
		add_random_phase(5'd16, TAIL_ITEMS, 1'b1, 1'b0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() != 0 || in_valid || cfg_valid || lookup_results_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (lookup_results_q.size() != 0)
			note_error($sformatf("%0d lookup results never arrived", lookup_results_q.size()));

		$display("Ran %0d gets (%0d hits, %0d misses) and %0d sets", gets_sent,
			hits_seen, misses_seen, sets_sent);
		$display("over %0d capacity writes and %0d full drains; %0d errors", cfg_writes,
			drains_done, err_cnt);
		if (err_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
